// File: rtl/heartbeat_node_monitor_macros.svh
// Assertion macros shared by the heartbeat node monitor RTL
`ifndef HEARTBEAT_NODE_MONITOR_MACROS_SVH
`define HEARTBEAT_NODE_MONITOR_MACROS_SVH

// same-cycle implication
`define HNM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heartbeat monitor check failed");

// next-cycle implication
`define HNM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heartbeat monitor check failed");

`endif

// File: rtl/hnm_pkg.sv
// Types, codes and helpers for the heartbeat node monitor
package hnm_pkg;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_READ  = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } state_e_t;

    localparam logic [2:0] REG_OWN_ID   = 3'd0;
    localparam logic [2:0] REG_OWN_STAT = 3'd1;
    localparam logic [2:0] REG_HB_BASE  = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;
    localparam logic [2:0] REG_UNKNOWN  = 3'd5;

    localparam logic [7:0]  UNKNOWN_RESET = 8'd0;
    localparam logic [10:0] HB_BASE_RESET = 11'd1792;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] PERIOD_RESET  = 16'd500;
    localparam int          LOST_W        = 16;

    typedef struct packed {
        logic [7:0]  status;
        logic [15:0] elapsed;
    } node_entry_t;

    typedef struct packed {
        req_e_t      op;
        logic        frame_hit;
        logic [6:0]  target;
        logic [6:0]  slot;
        logic [7:0]  frame_byte;
        logic [15:0] timeout;
        logic [7:0]  unknown_code;
    } upd_ctrl_t;

    typedef struct packed {
        logic lost;
        logic rd_hit;
    } upd_stat_t;

    function automatic logic [15:0] hnm_sat_add(logic [15:0] v, logic [15:0] inc);
        logic [16:0] s;
        s = {1'b0, v} + {1'b0, inc};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// File: rtl/hnm_cell.sv
// One ring cell: status and elapsed counter of one node entry
module hnm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  hnm_pkg::node_entry_t d,
    output hnm_pkg::node_entry_t q
);
    import hnm_pkg::*;

    node_entry_t q_reg;
    node_entry_t q_next;

    always_comb
    begin
        q_next = shift ? d : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '{status: UNKNOWN_RESET, elapsed: 16'd0};
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/hnm_update.sv
// Head-of-ring update of the entry passing slot zero
module hnm_update #(
    parameter int TICK_MS = 10
) (
    input  hnm_pkg::upd_ctrl_t   ctrl,
    input  hnm_pkg::node_entry_t entry_in,
    output hnm_pkg::node_entry_t entry_out,
    output hnm_pkg::upd_stat_t   stat
);
    import hnm_pkg::*;

    localparam logic [15:0] TICK_INC = 16'(TICK_MS);

    logic [15:0] el_sum;

    assign el_sum = hnm_sat_add(entry_in.elapsed, TICK_INC);

    always_comb
    begin
        entry_out   = entry_in;
        stat.lost   = 1'b0;
        stat.rd_hit = 1'b0;
        unique case (ctrl.op)
            REQ_FRAME:
            begin
                if (ctrl.frame_hit && ctrl.slot == ctrl.target)
                begin
                    entry_out.status  = ctrl.frame_byte;
                    entry_out.elapsed = 16'd0;
                end
            end
            REQ_TICK:
            begin
                entry_out.elapsed = el_sum;
                if (el_sum > ctrl.timeout && entry_in.status != ctrl.unknown_code)
                begin
                    entry_out.status  = ctrl.unknown_code;
                    entry_out.elapsed = 16'd0;
                    stat.lost         = 1'b1;
                end
            end
            REQ_READ:
            begin
                stat.rd_hit = (ctrl.slot == ctrl.target);
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

// File: rtl/heartbeat_node_monitor.sv
// Top level of the heartbeat node monitor: ring of node cells, sequencer, registers
//
// Each node entry (status byte, 16-bit elapsed counter) lives in one cell of a
// ring of NODE_COUNT cells. Every accepted word (frame, tick or status read)
// rotates the ring once: at each scan step the entry at the head is updated
// and passed to the tail, so after a full turn every entry is back in place.
// A word passes through accept, the rotation and the output load, in that
// order. One result word per input word is held in an output register; the
// next input is taken once that result has been loaded there. The node cells
// come up from reset directly; no clearing pass is needed.
`include "heartbeat_node_monitor_macros.svh"

module heartbeat_node_monitor #(
    parameter int NODE_COUNT = 16,
    parameter int ID_SPAN    = 15,
    parameter int TICK_MS    = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // frame_id[10:0], frame_byte[18:11], node_index[22:19]
    input  logic [1:0]  s_tuser,   // req_type
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_id[10:0], tx_byte[18:11], read_status[26:19],
                                   // lost_nodes[42:27]
    output logic        m_tuser,   // tx_valid
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hnm_pkg::*;

    localparam int          IDX_W     = $clog2(NODE_COUNT);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NODE_COUNT - 1);
    localparam logic [6:0]  NODES7    = 7'(NODE_COUNT);
    localparam logic [11:0] SPAN12    = 12'(ID_SPAN);
    localparam logic [15:0] TICK_INC  = 16'(TICK_MS);

    // configuration registers
    logic [3:0]  own_id_reg;
    logic [7:0]  own_stat_reg;
    logic [10:0] hb_base_reg;
    logic [15:0] timeout_reg;
    logic [15:0] period_reg;
    logic [7:0]  unknown_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= 4'd0;
            own_stat_reg <= 8'd0;
            hb_base_reg  <= HB_BASE_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            period_reg   <= PERIOD_RESET;
            unknown_reg  <= UNKNOWN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OWN_ID:   own_id_reg   <= pwdata[3:0];
                REG_OWN_STAT: own_stat_reg <= pwdata[7:0];
                REG_HB_BASE:  hb_base_reg  <= pwdata[10:0];
                REG_TIMEOUT:  timeout_reg  <= pwdata[15:0];
                REG_PERIOD:   period_reg   <= pwdata[15:0];
                REG_UNKNOWN:  unknown_reg  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OWN_ID:   prdata = {28'd0, own_id_reg};
            REG_OWN_STAT: prdata = {24'd0, own_stat_reg};
            REG_HB_BASE:  prdata = {21'd0, hb_base_reg};
            REG_TIMEOUT:  prdata = {16'd0, timeout_reg};
            REG_PERIOD:   prdata = {16'd0, period_reg};
            REG_UNKNOWN:  prdata = {24'd0, unknown_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // input word fields
    logic [10:0] in_fid;
    logic [7:0]  in_byte;
    logic [3:0]  in_nidx;
    req_e_t      in_req;
    logic [11:0] fid12;
    logic [11:0] base12;
    logic [10:0] k_off;
    logic        in_win;
    logic        in_hit;

    assign in_fid  = s_tdata[10:0];
    assign in_byte = s_tdata[18:11];
    assign in_nidx = s_tdata[22:19];
    assign in_req  = req_e_t'(s_tuser);
    assign fid12   = {1'b0, in_fid};
    assign base12  = {1'b0, hb_base_reg};
    assign k_off   = in_fid - hb_base_reg;
    assign in_win  = (fid12 >= base12) && (fid12 <= base12 + SPAN12);
    assign in_hit  = in_win && (7'(k_off) < NODES7);

    // sequencer
    state_e_t         state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             accept;
    logic             scan_en;
    logic             scan_last;
    logic             load_out;

    upd_ctrl_t   ctrl_reg;
    logic [3:0]  nidx_reg;
    logic [LOST_W-1:0] lost_reg;
    logic [7:0]  rd_cap_reg;
    logic [15:0] beat_reg;

    assign scan_last = (step_reg == LAST_STEP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_FLUSH;
            ST_FLUSH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        scan_en  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  scan_en  = 1'b1;
            ST_FLUSH: load_out = !m_tvalid || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    assign accept    = s_tvalid & s_tready;
    assign step_next = scan_en ? (scan_last ? '0 : step_reg + 1'b1) : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // latched request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg.op           <= in_req;
            ctrl_reg.frame_hit    <= in_hit;
            ctrl_reg.target       <= (in_req == REQ_READ) ? 7'(in_nidx) : 7'(k_off);
            ctrl_reg.slot         <= 7'd0;
            ctrl_reg.frame_byte   <= in_byte;
            ctrl_reg.timeout      <= timeout_reg;
            ctrl_reg.unknown_code <= unknown_reg;
            nidx_reg              <= in_nidx;
        end
    end

    // ring of cells
    node_entry_t cell_q [NODE_COUNT];
    node_entry_t head_out;
    upd_ctrl_t   ctrl_now;
    upd_stat_t   head_stat;

    always_comb
    begin
        ctrl_now      = ctrl_reg;
        ctrl_now.slot = 7'(step_reg);
    end

    hnm_update #(
        .TICK_MS (TICK_MS)
    ) u_update (
        .ctrl      (ctrl_now),
        .entry_in  (cell_q[0]),
        .entry_out (head_out),
        .stat      (head_stat)
    );

    for (genvar gi = 0; gi < NODE_COUNT; gi++)
    begin : g_ring
        hnm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (scan_en),
            .d     ((gi == NODE_COUNT - 1) ? head_out : cell_q[(gi + 1) % NODE_COUNT]),
            .q     (cell_q[gi])
        );
    end

    // per-word accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_reg   <= '0;
            rd_cap_reg <= 8'd0;
        end
        else if (accept)
        begin
            lost_reg   <= '0;
            rd_cap_reg <= 8'd0;
        end
        else if (scan_en)
        begin
            if (head_stat.lost && (7'(step_reg) < 7'(LOST_W)))
            begin
                lost_reg[4'(step_reg)] <= 1'b1;
            end
            if (head_stat.rd_hit)
            begin
                rd_cap_reg <= cell_q[0].status;
            end
        end
    end

    // own heartbeat and result assembly
    logic [15:0] beat_sum;
    logic        beat_fire;
    logic        is_tick;
    logic [7:0]  rd_value;
    logic        m_valid_reg;
    logic        tx_valid_reg;
    logic [10:0] tx_id_reg;
    logic [7:0]  tx_byte_reg;
    logic [7:0]  rd_status_reg;
    logic [LOST_W-1:0] lost_out_reg;

    assign is_tick   = (ctrl_reg.op == REQ_TICK);
    assign beat_sum  = hnm_sat_add(beat_reg, TICK_INC);
    assign beat_fire = is_tick && (beat_sum >= period_reg);

    always_comb
    begin
        priority if (ctrl_reg.op != REQ_READ)
            rd_value = 8'd0;
        else if (7'(nidx_reg) >= NODES7)
            rd_value = unknown_reg;
        else if (nidx_reg == own_id_reg)
            rd_value = own_stat_reg;
        else
            rd_value = rd_cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (load_out && is_tick)
            begin
                beat_reg <= beat_fire ? 16'd0 : beat_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tx_valid_reg  <= beat_fire;
            tx_id_reg     <= beat_fire ? 11'(hb_base_reg + {7'd0, own_id_reg}) : 11'd0;
            tx_byte_reg   <= beat_fire ? own_stat_reg : 8'd0;
            rd_status_reg <= rd_value;
            lost_out_reg  <= is_tick ? lost_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = tx_valid_reg;
    assign m_tdata  = {5'd0, lost_out_reg, rd_status_reg, tx_byte_reg, tx_id_reg};

    `HNM_ASSERT_NOW(a_idle_step_zero, state_reg == ST_IDLE, step_reg == '0)
    `HNM_ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == ST_SCAN)
    `HNM_ASSERT_NEXT(a_scan_end_flush, scan_en && scan_last, state_reg == ST_FLUSH)
    `HNM_ASSERT_NEXT(a_load_sets_valid, load_out, m_valid_reg)

endmodule

// File: sim/heartbeat_node_monitor_checker.sv
// Checker for the heartbeat node monitor: models the node table and compares every result word
module heartbeat_node_monitor_checker #(
    parameter int NODE_COUNT = 16,
    parameter int ID_SPAN    = 15,
    parameter int TICK_MS    = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import hnm_pkg::*;

    typedef struct {
        logic        beat;
        logic [10:0] beat_id;
        logic [7:0]  beat_byte;
        logic [7:0]  status;
        logic [15:0] lost;
    } reply_t;

    logic [3:0]  own_id;
    logic [7:0]  own_stat;
    logic [10:0] hb_base;
    logic [15:0] timeout_ms;
    logic [15:0] period_ms;
    logic [7:0]  unk_code;

    logic [7:0]  node_status [NODE_COUNT];
    logic [15:0] node_age [NODE_COUNT];
    logic [15:0] beat_age;

    reply_t replies [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] age_add(logic [15:0] v);
        int sum;
        sum = int'(v) + TICK_MS;
        if (sum > 65535)
            sum = 65535;
        return sum[15:0];
    endfunction

    task automatic reset_table();
        own_id     = '0;
        own_stat   = '0;
        hb_base    = HB_BASE_RESET;
        timeout_ms = TIMEOUT_RESET;
        period_ms  = PERIOD_RESET;
        unk_code   = UNKNOWN_RESET;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            node_status[i] = UNKNOWN_RESET;
            node_age[i]    = '0;
        end
        beat_age = '0;
    endtask

    task automatic write_setup(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_OWN_ID:   own_id     = val[3:0];
            REG_OWN_STAT: own_stat   = val[7:0];
            REG_HB_BASE:  hb_base    = val[10:0];
            REG_TIMEOUT:  timeout_ms = val[15:0];
            REG_PERIOD:   period_ms  = val[15:0];
            REG_UNKNOWN:  unk_code   = val[7:0];
            default:      ;
        endcase
    endtask

    // advance the node table by one word and return the word it answers
    function automatic reply_t table_step(logic [1:0] req, logic [10:0] fid,
                                          logic [7:0] fb, logic [3:0] ni);
        reply_t r;
        int     slot;
        r = '{beat: 1'b0, beat_id: '0, beat_byte: '0, status: '0, lost: '0};
        case (req)
            REQ_FRAME:
            begin
                slot = int'(fid) - int'(hb_base);
                if (slot >= 0 && slot <= ID_SPAN && slot < NODE_COUNT)
                begin
                    node_status[slot] = fb;
                    node_age[slot]    = '0;
                end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    node_age[i] = age_add(node_age[i]);
                    if (node_age[i] > timeout_ms && node_status[i] != unk_code)
                    begin
                        node_age[i]    = '0;
                        node_status[i] = unk_code;
                        if (i < 16)
                            r.lost[i] = 1'b1;
                    end
                end
                beat_age = age_add(beat_age);
                if (beat_age >= period_ms)
                begin
                    beat_age    = '0;
                    r.beat      = 1'b1;
                    r.beat_id   = hb_base + 11'(own_id);
                    r.beat_byte = own_stat;
                end
            end
            REQ_READ:
            begin
                if (int'(ni) < NODE_COUNT)
                    r.status = (ni == own_id) ? own_stat : node_status[ni];
                else
                    r.status = unk_code;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        if (!rst_n)
        begin
            reset_table();
            replies.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies.size() == 0)
                    flag_mismatch("word with nothing outstanding", m_tdata[31:0], '0);
                else
                begin
                    want = replies.pop_front();
                    if (m_tuser !== want.beat)
                        flag_mismatch("tx_valid", m_tuser, want.beat);
                    if (m_tdata[10:0] !== want.beat_id)
                        flag_mismatch("tx_id", m_tdata[10:0], want.beat_id);
                    if (m_tdata[18:11] !== want.beat_byte)
                        flag_mismatch("tx_byte", m_tdata[18:11], want.beat_byte);
                    if (m_tdata[26:19] !== want.status)
                        flag_mismatch("read_status", m_tdata[26:19], want.status);
                    if (m_tdata[42:27] !== want.lost)
                        flag_mismatch("lost_nodes", m_tdata[42:27], want.lost);
                    if (m_tdata[47:43] !== 5'd0)
                        flag_mismatch("tdata padding", m_tdata[47:43], '0);
                end
            end
            if (s_tvalid && s_tready)
                replies.push_back(table_step(s_tuser, s_tdata[10:0], s_tdata[18:11],
                                             s_tdata[22:19]));
            if (psel && penable && pwrite && pready)
                write_setup(paddr[4:2], pwdata);
        end
        pending = replies.size();
    end

endmodule

// File: sim/heartbeat_node_monitor_test.sv
// Testbench top for the heartbeat node monitor: stimulus, register setup and verdict
module heartbeat_node_monitor_test;
    import hnm_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_WORDS = 1700;
    localparam int RANDOM_PHASES = 8;
    localparam int SOAK_TICKS = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    logic [10:0] cur_base;
    logic [7:0]  cur_unk;

    heartbeat_node_monitor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    heartbeat_node_monitor_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("heartbeat_node_monitor verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_stall_pct);

    task automatic send_word(input logic [1:0] req, input logic [10:0] fid,
                             input logic [7:0] fb, input logic [3:0] ni);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {1'b0, ni, fb, fid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_setup(input logic [3:0] id, input logic [7:0] stat,
                                 input logic [10:0] base, input logic [15:0] tout,
                                 input logic [15:0] per, input logic [7:0] unk);
        wait_drained();
        write_reg(REG_OWN_ID, 32'(id));
        write_reg(REG_OWN_STAT, 32'(stat));
        write_reg(REG_HB_BASE, 32'(base));
        write_reg(REG_TIMEOUT, 32'(tout));
        write_reg(REG_PERIOD, 32'(per));
        write_reg(REG_UNKNOWN, 32'(unk));
        cur_base = base;
        cur_unk  = unk;
    endtask

    // extremes a quarter of the time, otherwise a value in the busy range
    function automatic logic [15:0] pick_value(int top_val, int busy_max);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'(top_val);
        return 16'($urandom_range(busy_max));
    endfunction

    task automatic random_word();
        int          r;
        logic [1:0]  req;
        logic [10:0] fid;
        logic [7:0]  fb;
        logic [3:0]  ni;
        r   = $urandom_range(99);
        fid = 11'($urandom_range(2047));
        fb  = 8'($urandom_range(255));
        ni  = 4'($urandom_range(15));
        if (r < 40)
        begin
            req = REQ_FRAME;
            if ($urandom_range(4) != 0)
                fid = cur_base + 11'($urandom_range(15));
            if ($urandom_range(4) == 0)
                fb = cur_unk;
        end
        else if (r < 75)
            req = REQ_TICK;
        else if (r < 95)
            req = REQ_READ;
        else
            req = REQ_NONE;
        send_word(req, fid, fb, ni);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stored statuses keep the old unknown code; own entry on frames and ticks
        program_setup(4'd15, 8'hA5, 11'd2032, 16'd0, 16'd0, 8'hFF);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd15);
        send_word(REQ_FRAME, 11'd2032, 8'h00, 4'd0);
        send_word(REQ_FRAME, 11'd2047, 8'hFF, 4'd15);
        send_word(REQ_FRAME, 11'd2031, 8'h12, 4'd3);
        send_word(REQ_FRAME, 11'd0, 8'h34, 4'd9);
        send_word(REQ_READ, 11'd2047, 8'hFF, 4'd15);
        send_word(REQ_TICK, 11'd0, 8'd0, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd3);
        send_word(REQ_NONE, 11'h7FF, 8'hFF, 4'hF);
        send_word(REQ_TICK, 11'h7FF, 8'hFF, 4'hF);

        program_setup(4'd0, 8'h00, 11'd2047, 16'hFFFF, 16'hFFFF, 8'h00);
        send_word(REQ_FRAME, 11'd2047, 8'h80, 4'd0);
        send_word(REQ_FRAME, 11'd2046, 8'h55, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd1);
        send_word(REQ_TICK, 11'd0, 8'd0, 4'd0);

        program_setup(4'd5, 8'h3C, 11'd0, 16'd10, 16'd20, 8'h00);
        send_word(REQ_FRAME, 11'd0, 8'h01, 4'd0);
        send_word(REQ_FRAME, 11'd15, 8'h7F, 4'd0);
        send_word(REQ_FRAME, 11'd16, 8'h66, 4'd0);
        send_word(REQ_TICK, 11'd0, 8'd0, 4'd0);
        send_word(REQ_TICK, 11'd0, 8'd0, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd5);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd15);

        // long silence under a full-scale timeout, then a short timeout drops every node at once
        program_setup(4'($urandom_range(15)), 8'($urandom_range(255)), 11'd1792,
                      16'hFFFF, 16'hFFFF, 8'h00);
        for (int n = 0; n < 16; n++)
            send_word(REQ_FRAME, 11'd1792 + 11'(n), 8'($urandom_range(1, 255)),
                      4'($urandom_range(15)));
        for (int n = 0; n < SOAK_TICKS; n++)
        begin
            if ($urandom_range(19) == 0)
                send_word(REQ_READ, 11'($urandom_range(2047)), 8'($urandom_range(255)),
                          4'($urandom_range(15)));
            else
                send_word(REQ_TICK, 11'($urandom_range(2047)), 8'($urandom_range(255)),
                          4'($urandom_range(15)));
        end
        wait_drained();
        write_reg(REG_TIMEOUT, 32'd100);
        send_word(REQ_TICK, 11'd0, 8'd0, 4'd0);
        send_word(REQ_READ, 11'd0, 8'd0, 4'd7);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_setup(4'(pick_value(15, 15)), 8'(pick_value(255, 255)),
                          11'(pick_value(2047, 2047)), pick_value(65535, 300),
                          pick_value(65535, 200), 8'(pick_value(255, 255)));
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            for (int n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++)
            begin
                if ($urandom_range(149) == 0)
                    wait_drained();
                random_word();
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_drained();
        repeat (40) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("heartbeat_node_monitor verification clean");
        else
            $display("heartbeat_node_monitor verification failed");
        $finish;
    end

endmodule
